>>> hdl/cosine_similarity_top_assert.svh
// ----------------------------------------------------------------------------
// Cosine similarity assertion macros
// Shared concurrent assertion forms clocked on clk_i and gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef COSINE_SIMILARITY_TOP_ASSERT_SVH
`define COSINE_SIMILARITY_TOP_ASSERT_SVH

// Same-cycle implication.
`define CS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cosine similarity check failed");

// Next-cycle implication.
`define CS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cosine similarity check failed");

`endif

>>> hdl/cs_pkg.sv
// ----------------------------------------------------------------------------
// Cosine similarity package
// Widths, datapath commands and controller/datapath status types.
// ----------------------------------------------------------------------------
package cs_pkg;

  localparam int DOT_W    = 44;
  localparam int NORM_W   = 43;
  localparam int SIM_W    = 16;
  localparam int MUL_W    = 2 * DOT_W;
  localparam int SRCH_W   = 119;
  localparam int MUL_STEPS = DOT_W;
  localparam int Q_BITS   = 16;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_MUL_P_LOAD,
    OP_MUL_R_LOAD,
    OP_MUL_STEP,
    OP_SRCH_LOAD,
    OP_SRCH_A,
    OP_SRCH_B,
    OP_SRCH_C,
    OP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic zero_norm;
    logic out_busy;
  } dp_status_t;

endpackage

>>> hdl/cs_if.sv
// ----------------------------------------------------------------------------
// Cosine similarity channel interfaces
// Valid/ready channels for element pairs and similarity results.
// ----------------------------------------------------------------------------
interface cs_in_if #(
  parameter int ELEM_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [ELEM_WIDTH-1:0] x_elem;
  logic signed [ELEM_WIDTH-1:0] y_elem;
  logic                         last_elem;

  modport source (output valid, x_elem, y_elem, last_elem, input ready);
  modport sink (input valid, x_elem, y_elem, last_elem, output ready);
endinterface

interface cs_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] similarity;
  logic               zero_norm;

  modport source (output valid, similarity, zero_norm, input ready);
  modport sink (input valid, similarity, zero_norm, output ready);
endinterface

>>> hdl/cosine_similarity_top.sv
// Cosine similarity of two streamed signed vectors. Element pairs are taken one beat per
// cycle while a vector is streaming; the beat marked last closes the vector, and the block
// then stops taking input while one serial shift-add multiplier forms the norm product and
// the squared dot product, a bitwise search finds the Q1.15 quotient over 16 bits and the
// previous result leaves the output register. The result waits in an output register, and
// the next vector may stream in while it does.
// ----------------------------------------------------------------------------
// Cosine similarity top level
// Joins the controller and datapath to the element and result channels.
// ----------------------------------------------------------------------------
`include "cosine_similarity_top_assert.svh"

module cosine_similarity_top #(
  parameter int ELEM_WIDTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  cs_in_if.sink    in_i,
  cs_out_if.source out_o
);
  import cs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       beat;

  assign beat = in_i.valid && in_i.ready;

  cs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last_elem),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cs_dp #(
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_i       (beat),
    .x_i          (in_i.x_elem),
    .y_i          (in_i.y_elem),
    .last_i       (in_i.last_elem),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .similarity_o (out_o.similarity),
    .zero_norm_o  (out_o.zero_norm)
  );

  `CS_ASSERT_IMP(a_zero_sim, out_o.valid && out_o.zero_norm, out_o.similarity == '0)
  `CS_ASSERT_NXT(a_last_stalls, beat && in_i.last_elem, !in_i.ready)
  `CS_ASSERT_IMP(a_result_when_free, cmd.op == OP_RESULT, !status.out_busy)
endmodule

>>> hdl/cs_dp.sv
// ----------------------------------------------------------------------------
// Cosine similarity datapath
// Product and accumulator stages, serial multiplier, bitwise quotient
// search and the result register.
// ----------------------------------------------------------------------------
module cs_dp #(
  parameter int ELEM_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         beat_i,
  input  logic signed [ELEM_WIDTH-1:0] x_i,
  input  logic signed [ELEM_WIDTH-1:0] y_i,
  input  logic                         last_i,
  input  cs_pkg::dp_cmd_t              cmd_i,
  output cs_pkg::dp_status_t           status_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic signed [15:0]           similarity_o,
  output logic                         zero_norm_o
);
  import cs_pkg::*;

  logic signed [2*ELEM_WIDTH-1:0] pxy_q, pxx_q, pyy_q;
  logic                           pv_q, plast_q;
  logic [DOT_W-1:0]               dot_acc_q, dot_sum, dot_s_q;
  logic [NORM_W-1:0]              nx_acc_q, nx_sum, nx_s_q;
  logic [NORM_W-1:0]              ny_acc_q, ny_sum, ny_s_q;
  logic                           neg;
  logic [DOT_W-1:0]               mag;
  logic [DOT_W-1:0]               ma_q, mb_q;
  logic [MUL_W-1:0]               mp_q;
  logic [MUL_W-1:0]               p_q;
  logic [SRCH_W-1:0]              r_q, t_q, us_q, pb_q, s_q, c_q;
  logic                           fit;
  logic [Q_BITS-1:0]              q_q, qc, qpos;
  logic                           out_valid_q, zero_q;
  logic signed [SIM_W-1:0]        sim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= beat_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_i) begin
      pxy_q   <= x_i * y_i;
      pxx_q   <= x_i * x_i;
      pyy_q   <= y_i * y_i;
      plast_q <= last_i;
    end
  end

  assign dot_sum = dot_acc_q + DOT_W'(pxy_q);
  assign nx_sum  = nx_acc_q + NORM_W'(pxx_q);
  assign ny_sum  = ny_acc_q + NORM_W'(pyy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_acc_q <= '0;
      nx_acc_q  <= '0;
      ny_acc_q  <= '0;
    end else if (pv_q) begin
      if (plast_q) begin
        dot_acc_q <= '0;
        nx_acc_q  <= '0;
        ny_acc_q  <= '0;
      end else begin
        dot_acc_q <= dot_sum;
        nx_acc_q  <= nx_sum;
        ny_acc_q  <= ny_sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pv_q && plast_q) begin
      dot_s_q <= dot_sum;
      nx_s_q  <= nx_sum;
      ny_s_q  <= ny_sum;
    end
  end

  assign neg = dot_s_q[DOT_W-1];
  assign mag = neg ? (~dot_s_q + DOT_W'(1)) : dot_s_q;
  assign fit = (c_q <= r_q);

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_MUL_P_LOAD: begin
        ma_q <= DOT_W'(nx_s_q);
        mb_q <= DOT_W'(ny_s_q);
        mp_q <= '0;
      end
      OP_MUL_R_LOAD: begin
        p_q  <= mp_q;
        ma_q <= mag;
        mb_q <= mag;
        mp_q <= '0;
      end
      OP_MUL_STEP: begin
        mp_q <= (mp_q << 1) + (mb_q[DOT_W-1] ? MUL_W'(ma_q) : '0);
        mb_q <= mb_q << 1;
      end
      OP_SRCH_LOAD: begin
        r_q  <= SRCH_W'(mp_q) << 30;
        t_q  <= '0;
        us_q <= '0;
        pb_q <= SRCH_W'(p_q) << 30;
        q_q  <= '0;
      end
      OP_SRCH_A: begin
        s_q <= t_q + us_q;
      end
      OP_SRCH_B: begin
        c_q <= s_q + pb_q;
      end
      OP_SRCH_C: begin
        if (fit) begin
          t_q <= c_q;
        end
        us_q <= (fit ? (us_q + (pb_q << 1)) : us_q) >> 1;
        pb_q <= pb_q >> 2;
        q_q  <= {q_q[Q_BITS-2:0], fit};
      end
      default: begin
      end
    endcase
  end

  assign qc   = (q_q > 16'h8000) ? 16'h8000 : q_q;
  assign qpos = (qc > 16'h7fff) ? 16'h7fff : qc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_RESULT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_RESULT) begin
      if (status_o.zero_norm) begin
        sim_q  <= '0;
        zero_q <= 1'b1;
      end else begin
        sim_q  <= neg ? -$signed(qc) : $signed(qpos);
        zero_q <= 1'b0;
      end
    end
  end

  assign status_o.zero_norm = (nx_s_q == '0) || (ny_s_q == '0);
  assign status_o.out_busy  = out_valid_q && !out_ready_i;
  assign out_valid_o  = out_valid_q;
  assign similarity_o = sim_q;
  assign zero_norm_o  = zero_q;
endmodule

>>> hdl/cs_ctrl.sv
// ----------------------------------------------------------------------------
// Cosine similarity controller
// Sequences accumulation, the two serial products and the quotient search.
// ----------------------------------------------------------------------------
module cs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  output logic               in_ready_o,
  input  cs_pkg::dp_status_t status_i,
  output cs_pkg::dp_cmd_t    cmd_o
);
  import cs_pkg::*;

  typedef enum logic [3:0] {
    S_ACC, S_SNAP, S_SETUP, S_MUL_P, S_RLOAD, S_MUL_R, S_SLOAD,
    S_SRCH_A, S_SRCH_B, S_SRCH_C, S_DONE
  } state_e;

  state_e     state_q;
  logic       in_ready_q;
  logic [5:0] cnt_q;
  logic [3:0] bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_ACC;
      in_ready_q <= 1'b0;
      cnt_q      <= '0;
      bit_q      <= '0;
    end else begin
      case (state_q)
        S_ACC: begin
          in_ready_q <= 1'b1;
          if (in_valid_i && in_ready_q && in_last_i) begin
            in_ready_q <= 1'b0;
            state_q    <= S_SNAP;
          end
        end
        S_SNAP: begin
          state_q <= S_SETUP;
        end
        S_SETUP: begin
          cnt_q   <= '0;
          state_q <= status_i.zero_norm ? S_DONE : S_MUL_P;
        end
        S_MUL_P: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(MUL_STEPS - 1)) begin
            state_q <= S_RLOAD;
          end
        end
        S_RLOAD: begin
          cnt_q   <= '0;
          state_q <= S_MUL_R;
        end
        S_MUL_R: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(MUL_STEPS - 1)) begin
            state_q <= S_SLOAD;
          end
        end
        S_SLOAD: begin
          bit_q   <= '0;
          state_q <= S_SRCH_A;
        end
        S_SRCH_A: begin
          state_q <= S_SRCH_B;
        end
        S_SRCH_B: begin
          state_q <= S_SRCH_C;
        end
        S_SRCH_C: begin
          bit_q   <= bit_q + 4'd1;
          state_q <= (bit_q == 4'(Q_BITS - 1)) ? S_DONE : S_SRCH_A;
        end
        S_DONE: begin
          if (!status_i.out_busy) begin
            in_ready_q <= 1'b1;
            state_q    <= S_ACC;
          end
        end
        default: begin
          state_q <= S_ACC;
        end
      endcase
    end
  end

  always_comb begin
    case (state_q)
      S_SETUP:  cmd_o.op = status_i.zero_norm ? OP_IDLE : OP_MUL_P_LOAD;
      S_MUL_P:  cmd_o.op = OP_MUL_STEP;
      S_RLOAD:  cmd_o.op = OP_MUL_R_LOAD;
      S_MUL_R:  cmd_o.op = OP_MUL_STEP;
      S_SLOAD:  cmd_o.op = OP_SRCH_LOAD;
      S_SRCH_A: cmd_o.op = OP_SRCH_A;
      S_SRCH_B: cmd_o.op = OP_SRCH_B;
      S_SRCH_C: cmd_o.op = OP_SRCH_C;
      S_DONE:   cmd_o.op = status_i.out_busy ? OP_IDLE : OP_RESULT;
      default:  cmd_o.op = OP_IDLE;
    endcase
  end

  assign in_ready_o = in_ready_q;
endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// Cosine similarity testbench
// Streams element-pair vectors with random gaps and output stalls, predicts
// each Q1.15 similarity with an exact integer search, and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int RANDOM_VECTORS = 260;

  typedef struct packed {
    logic signed [15:0] similarity;
    logic               zero_norm;
  } sim_result_t;

  class similarity_board;
    logic [cs_pkg::DOT_W-1:0]  dot_sum;
    logic [cs_pkg::NORM_W-1:0] xx_sum;
    logic [cs_pkg::NORM_W-1:0] yy_sum;
    sim_result_t               pending_q[$];
    int                        errors;

    function new();
      dot_sum = '0;
      xx_sum  = '0;
      yy_sum  = '0;
      errors  = 0;
    endfunction

    function sim_result_t similarity_of(logic [cs_pkg::DOT_W-1:0] d,
                                        logic [cs_pkg::NORM_W-1:0] nx,
                                        logic [cs_pkg::NORM_W-1:0] ny);
      sim_result_t r;
      logic [cs_pkg::DOT_W-1:0] mag;
      logic [127:0] prod;
      logic [127:0] rhs;
      logic [63:0]  a;
      int unsigned  lo;
      int unsigned  hi;
      int unsigned  mid;
      r.similarity = '0;
      r.zero_norm  = 1'b0;
      if (nx == 0 || ny == 0) begin
        r.zero_norm = 1'b1;
        return r;
      end
      mag  = d[cs_pkg::DOT_W-1] ? (~d + 1'b1) : d;
      prod = 128'(nx) * 128'(ny);
      a    = 64'(mag) << 15;
      rhs  = 128'(a) * 128'(a);
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (prod * 128'(mid) * 128'(mid) <= rhs) lo = mid;
        else hi = mid - 1;
      end
      if (d[cs_pkg::DOT_W-1]) r.similarity = 16'(-lo);
      else r.similarity = (lo > 32767) ? 16'sd32767 : 16'(lo);
      return r;
    endfunction

    function void note_pair(logic signed [15:0] x, logic signed [15:0] y, logic last);
      logic signed [31:0] xy;
      xy = x * y;
      dot_sum = dot_sum + {{(cs_pkg::DOT_W-32){xy[31]}}, xy};
      xx_sum  = xx_sum + cs_pkg::NORM_W'(32'(x * x));
      yy_sum  = yy_sum + cs_pkg::NORM_W'(32'(y * y));
      if (last) begin
        pending_q = {pending_q, similarity_of(dot_sum, xx_sum, yy_sum)};
        dot_sum = '0;
        xx_sum  = '0;
        yy_sum  = '0;
      end
    endfunction

    function void check_result(logic signed [15:0] sim, logic zn);
      sim_result_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result sim=%0d zero_norm=%0b", $time, sim, zn);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (sim !== e.similarity) begin
        $display("%0t: similarity expected %0d actual %0d", $time, e.similarity, sim);
        errors++;
      end
      if (zn !== e.zero_norm) begin
        $display("%0t: zero_norm expected %0b actual %0b", $time, e.zero_norm, zn);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   cycle_cnt;
  bit   quiet_mode;
  bit   hold_out;

  cs_in_if #(.ELEM_WIDTH(16)) in_if ();
  cs_out_if out_if ();

  similarity_board board;

  cosine_similarity_top #(.ELEM_WIDTH(16)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    in_if.valid     = 1'b0;
    in_if.x_elem    = '0;
    in_if.y_elem    = '0;
    in_if.last_elem = 1'b0;
    out_if.ready    = 1'b0;
    rst_ni          = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  initial cycle_cnt = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        board.note_pair(in_if.x_elem, in_if.y_elem, in_if.last_elem);
      if (out_if.valid && out_if.ready)
        board.check_result(out_if.similarity, out_if.zero_norm);
      out_if.ready <= !hold_out && (quiet_mode || $urandom_range(99) >= 6);
    end
  end

  task automatic send_pair(logic signed [15:0] x, logic signed [15:0] y, logic last);
    while (!quiet_mode && $urandom_range(99) < 6) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.x_elem    <= x;
    in_if.y_elem    <= y;
    in_if.last_elem <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_elem(int kind);
    case (kind)
      0: return 16'($urandom());
      1: return 16'($urandom_range(7)) - 16'sd4;
      2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($urandom_range(255)) - 16'sd128;
    endcase
  endfunction

  task automatic send_vector(int len, int kind, int rel);
    logic signed [15:0] x;
    logic signed [15:0] y;
    for (int i = 0; i < len; i++) begin
      x = rand_elem(kind);
      case (rel)
        0: y = x;
        1: y = -x;
        2: y = '0;
        default: y = rand_elem(kind);
      endcase
      send_pair(x, y, i == len - 1);
    end
  endtask

  initial begin
    board      = new();
    quiet_mode = 1'b0;
    hold_out   = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);

    send_pair(16'sh7fff, 16'sh7fff, 1'b1);
    send_pair(16'sh8000, 16'sh8000, 1'b1);
    send_pair(16'sh8000, 16'sh7fff, 1'b1);
    send_pair(16'sh7fff, 16'sh8000, 1'b1);
    send_pair(16'sd0, 16'sd5, 1'b1);
    send_pair(16'sd3, 16'sd0, 1'b1);
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(16'sd1, 16'sd0, 1'b0);
    send_pair(16'sd0, 16'sd1, 1'b1);
    send_pair(16'sd3, 16'sd4, 1'b0);
    send_pair(16'sd4, -16'sd3, 1'b1);
    send_pair(16'sh8000, 16'sh8000, 1'b0);
    send_pair(16'sh8000, 16'sh8000, 1'b0);
    send_pair(16'sh8000, 16'sh8000, 1'b1);
    send_pair(-16'sd1, 16'sd1, 1'b0);
    send_pair(16'sd1, 16'sd1, 1'b1);
    send_pair(16'sh5555, 16'shaaaa, 1'b1);
    wait_drained();

    for (int v = 0; v < RANDOM_VECTORS; v++) begin
      if (v == 60) quiet_mode = 1'b1;
      if (v == 120) quiet_mode = 1'b0;
      if (v == 150) begin
        fork
          begin
            hold_out = 1'b1;
            repeat (600) @(posedge clk_i);
            hold_out = 1'b0;
          end
        join_none
      end
      if (v == 200) wait_drained();
      send_vector($urandom_range(9) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 8),
                  $urandom_range(3), $urandom_range(4));
    end
    wait_drained();
    repeat (200) @(posedge clk_i);

    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
